/* rtl/core/ttcw_pkg.sv */
// ----------------------------------------------------------------------------
// ttcw_pkg
// Shared types and constants for the text terminal character writer: item and
// result payloads, controller states, and the command and status bundles.
// ----------------------------------------------------------------------------
package ttcw_pkg;

  localparam logic [7:0]  NEWLINE_CODE = 8'd10;
  localparam logic [7:0]  SPACE_CODE   = 8'h20;
  localparam logic [7:0]  RESET_COLOR  = 8'h07;
  localparam logic [15:0] RESET_BLANK  = {RESET_COLOR, SPACE_CODE};

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } ttcw_item_t;

  typedef struct packed {
    logic [10:0] cursor_offset;
    logic [15:0] cell_value;
    logic        scrolled;
  } ttcw_result_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } ttcw_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic put;        // put item accepted this cycle
    logic read;       // read item accepted this cycle
    logic read_done;  // cell data for the read item is available
    logic clear;      // one step of the clearing pass after reset
    logic scroll;     // one step of the scroll sweep
  } ttcw_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic item_read;    // the offered item is a read
    logic put_scrolls;  // the offered put moves past the last row
    logic clear_last;   // clearing pass is at its last cell
    logic scroll_last;  // scroll sweep is at its last step
  } ttcw_sts_t;

endpackage

/* rtl/core/text_terminal_char_writer.sv */
// ----------------------------------------------------------------------------
// text_terminal_char_writer
// Text-mode screen writer: puts characters at a cursor with the configured
// color, wraps and scrolls, and reads back single screen cells.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// result_o for exactly one cycle with done_o high, and must be captured then.
// A put item that stays on the screen leaves busy low and its result follows
// in the next cycle, so such puts can be issued back to back. A read item
// keeps busy high for one cycle; its cell is read into rd_data_q and then
// registered with done_o. A put that moves past the last row scrolls the
// screen: the screen memory, with one write and one read port, is swept once,
// one cell per cycle, and busy stays high for the whole sweep before the
// result. After reset a clearing pass writes every cell, keeping busy high
// until it ends; configuration writes are accepted during that time.
module text_terminal_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  ttcw_pkg::ttcw_item_t   item_i,
  output logic                   done_o,
  output ttcw_pkg::ttcw_result_t result_o,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i
);

  ttcw_pkg::ttcw_cmd_t cmd;
  ttcw_pkg::ttcw_sts_t sts;

  ttcw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ttcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

/* rtl/core/ttcw_ctrl.sv */
// ----------------------------------------------------------------------------
// ttcw_ctrl
// Controller for the text terminal writer: sequences the clearing pass, read
// items and the scroll sweep, and drives busy.
// ----------------------------------------------------------------------------
module ttcw_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ttcw_pkg::ttcw_sts_t sts_i,
  output ttcw_pkg::ttcw_cmd_t cmd_o
);

  ttcw_pkg::ttcw_state_e state_q, state_d;
  logic accept;

  assign accept = start && (state_q == ttcw_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ttcw_pkg::ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ttcw_pkg::ST_IDLE;
      end
      ttcw_pkg::ST_IDLE: begin
        if (start) begin
          if (sts_i.item_read) begin
            state_d = ttcw_pkg::ST_READ;
          end else if (sts_i.put_scrolls) begin
            state_d = ttcw_pkg::ST_SCROLL;
          end
        end
      end
      ttcw_pkg::ST_READ: begin
        state_d = ttcw_pkg::ST_IDLE;
      end
      ttcw_pkg::ST_SCROLL: begin
        if (sts_i.scroll_last) state_d = ttcw_pkg::ST_IDLE;
      end
      default: begin
        state_d = ttcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy            = (state_q != ttcw_pkg::ST_IDLE);
    cmd_o.put       = accept && !sts_i.item_read;
    cmd_o.read      = accept && sts_i.item_read;
    cmd_o.read_done = (state_q == ttcw_pkg::ST_READ);
    cmd_o.clear     = (state_q == ttcw_pkg::ST_CLEAR);
    cmd_o.scroll    = (state_q == ttcw_pkg::ST_SCROLL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ttcw_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/ttcw_datapath.sv */
// ----------------------------------------------------------------------------
// ttcw_datapath
// Screen memory, cursor, color register and result registers of the text
// terminal writer, with the sweep counter used for clearing and scrolling.
// ----------------------------------------------------------------------------
module ttcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ttcw_pkg::ttcw_cmd_t    cmd_i,
  output ttcw_pkg::ttcw_sts_t    sts_o,
  input  ttcw_pkg::ttcw_item_t   item_i,
  input  logic                   cfg_we_i,
  input  logic [7:0]             cfg_wdata_i,
  output logic                   done_o,
  output ttcw_pkg::ttcw_result_t result_o
);

  localparam int CELLS      = ROWS * COLUMNS;
  localparam int COPY_CELLS = CELLS - COLUMNS;
  localparam int AW         = $clog2(CELLS);
  localparam int SW         = $clog2(CELLS + 1);
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLUMNS);
  localparam int EW         = SW + 11;

  logic [15:0]   mem_q [CELLS];
  logic [15:0]   rd_data_q;
  logic [7:0]    color_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [SW-1:0] sweep_q;
  logic          idx_ok_q;
  logic          done_q;
  logic [15:0]   cell_q;
  logic          scrolled_q;

  logic          is_newline;
  logic          last_col;
  logic          last_row;
  logic          wrap;
  logic [AW-1:0] cur_addr;
  logic [SW-1:0] cur_offset;
  logic [EW-1:0] offset_ext;
  logic [EW-1:0] idx_ext;
  logic          idx_ok;
  logic [SW:0]   src_pos;
  logic          src_ok;
  logic [SW-1:0] dst_pos;
  logic          copy_phase;

  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  assign is_newline = (item_i.char_code == ttcw_pkg::NEWLINE_CODE);
  assign last_col   = (col_q == CW'(COLUMNS - 1));
  assign last_row   = (row_q == RW'(ROWS - 1));
  assign wrap       = is_newline || last_col;

  assign cur_addr   = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
  assign cur_offset = SW'(row_q) * SW'(COLUMNS) + SW'(col_q);
  assign offset_ext = {11'd0, cur_offset};

  assign idx_ext = {{SW{1'b0}}, item_i.cell_index};
  assign idx_ok  = (idx_ext < EW'(CELLS));

  // During a scroll, cell s+COLUMNS is read at step s and written to cell s
  // at step s+1; the cells of the bottom row get the blank instead.
  assign src_pos    = (SW + 1)'(sweep_q) + (SW + 1)'(COLUMNS);
  assign src_ok     = (src_pos < (SW + 1)'(CELLS));
  assign dst_pos    = sweep_q - SW'(1);
  assign copy_phase = (sweep_q <= SW'(COPY_CELLS));

  assign sts_o.item_read   = item_i.kind;
  assign sts_o.put_scrolls = !item_i.kind && wrap && last_row;
  assign sts_o.clear_last  = (sweep_q == SW'(CELLS - 1));
  assign sts_o.scroll_last = (sweep_q == SW'(CELLS));

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {color_q, item_i.char_code};
    if (cmd_i.clear) begin
      we    = 1'b1;
      waddr = sweep_q[AW-1:0];
      wdata = ttcw_pkg::RESET_BLANK;
    end else if (cmd_i.scroll) begin
      we    = (sweep_q != '0);
      waddr = dst_pos[AW-1:0];
      wdata = copy_phase ? rd_data_q : {color_q, ttcw_pkg::SPACE_CODE};
    end else if (cmd_i.put && !is_newline) begin
      we = 1'b1;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = idx_ext[AW-1:0];
    if (cmd_i.scroll) begin
      re    = src_ok;
      raddr = src_pos[AW-1:0];
    end else if (cmd_i.read) begin
      re = idx_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (re) rd_data_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q  <= ttcw_pkg::RESET_COLOR;
      row_q    <= '0;
      col_q    <= '0;
      sweep_q  <= '0;
      idx_ok_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_we_i) color_q <= cfg_wdata_i;
      if (cmd_i.put) begin
        if (wrap) begin
          col_q <= '0;
          if (!last_row) row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
      if (cmd_i.clear) begin
        sweep_q <= sts_o.clear_last ? '0 : sweep_q + SW'(1);
      end else if (cmd_i.scroll) begin
        sweep_q <= sts_o.scroll_last ? '0 : sweep_q + SW'(1);
      end else if (cmd_i.put) begin
        sweep_q <= '0;
      end
      if (cmd_i.read) idx_ok_q <= idx_ok;
      done_q <= (cmd_i.put && !sts_o.put_scrolls) || cmd_i.read_done
              || (cmd_i.scroll && sts_o.scroll_last);
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q     <= (cmd_i.read_done && idx_ok_q) ? rd_data_q : 16'd0;
    scrolled_q <= cmd_i.scroll && sts_o.scroll_last;
  end

  assign done_o                 = done_q;
  assign result_o.cursor_offset = offset_ext[10:0];
  assign result_o.cell_value    = cell_q;
  assign result_o.scrolled      = scrolled_q;

`ifndef SYNTHESIS
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= RW'(ROWS - 1)) && (col_q <= CW'(COLUMNS - 1)))
    else $error("cursor left the screen");

  a_scroll_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scroll && sts_o.scroll_last |=> done_q && scrolled_q)
    else $error("scroll sweep ended without a scrolled result");

  a_scroll_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put && sts_o.put_scrolls |=> !done_q)
    else $error("scrolling put gave its result before the sweep");

  a_scrolled_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && scrolled_q |-> cell_q == 16'd0)
    else $error("scrolled result carries cell data");
`endif

endmodule
